// ----- sv/q24alu_pkg.sv -----
// Package: opcodes and item types for the Q24.8 fixed-point ALU.
`default_nettype none
package q24alu_pkg;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_INC      = 4'd4,
    OP_DEC      = 4'd5,
    OP_MIN      = 4'd6,
    OP_MAX      = 4'd7,
    OP_CMP      = 4'd8,
    OP_FROM_INT = 4'd9,
    OP_TO_INT   = 4'd10,
    OP_FROM_FLT = 4'd11,
    OP_TO_FLT   = 4'd12
  } op_e;

  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] a_word;
    logic [31:0] b_word;
  } in_item_t;

  typedef struct packed {
    logic [31:0] result_word;
    logic        is_less;
    logic        is_equal;
    logic        is_greater;
    logic        divide_by_zero;
  } out_item_t;

endpackage
`default_nettype wire

// ----- sv/q24_8_fixed_point_alu_top.sv -----
// Top level: pipelined Q24.8 fixed-point ALU with a bit-per-stage divider.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i / in_stall_o   | q24alu_pkg::in_item_t
//   out     | output    | out_valid_o / out_stall_i | q24alu_pkg::out_item_t
//
// One item enters per cycle unless the output stalls; the pipeline depth is set
// by the restoring divider, one quotient bit a stage.
// Other opcodes ride the same pipeline so results leave in order.
// Reset clears only the stage valid bits.
// When the last stage holds an item and out is stalled, the whole pipe holds.
`default_nettype none
module q24_8_fixed_point_alu_top #(
  parameter int FRAC_W    = 8,
  parameter int WORD_BITS = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire q24alu_pkg::in_item_t  in_item_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output q24alu_pkg::out_item_t      out_item_o
);
  import q24alu_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_W;
  localparam int QB = W + F;
  localparam int D  = QB + 2;
  localparam int PW = $clog2(W) + 1;
  localparam logic [7:0] EXP_BIAS = 8'(127 - F);

  typedef struct packed {
    logic [3:0]    kind;
    logic [31:0]   res;
    logic          lt;
    logic          eq;
    logic          gt;
    logic          dz;
    logic          qneg;
    logic [QB-1:0] num;
    logic [W-1:0]  den;
    logic [W-1:0]  rem;
    logic [QB-1:0] quo;
  } stage_t;

  function automatic logic [31:0] zx(input logic [W-1:0] x);
    return 32'(x);
  endfunction

  // one restoring division step
  function automatic stage_t div_step(input stage_t s);
    stage_t      o;
    logic [W:0]  sh;
    o  = s;
    sh = {s.rem, s.num[QB-1]};
    if (sh >= {1'b0, s.den}) begin
      o.rem = W'(sh - {1'b0, s.den});
      o.quo = {s.quo[QB-2:0], 1'b1};
    end else begin
      o.rem = sh[W-1:0];
      o.quo = {s.quo[QB-2:0], 1'b0};
    end
    o.num = {s.num[QB-2:0], 1'b0};
    return o;
  endfunction

  logic            en;
  logic [D-1:0]    vld_q;
  stage_t          pipe_q [D];
  stage_t          pipe_d [D];

  logic signed [2*W-1:0] prod_q, prod_d;
  logic [W-1:0]          tf_mag0_q, tf_mag0_d, tf_mag1_q;
  logic                  tf_neg0_q, tf_neg0_d, tf_neg1_q;
  logic [PW-1:0]         tf_p1_q, tf_p1_d;

  assign en          = !(vld_q[D-1] && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = vld_q[D-1];
  assign out_item_o.result_word    = pipe_q[D-1].res;
  assign out_item_o.is_less        = pipe_q[D-1].lt;
  assign out_item_o.is_equal       = pipe_q[D-1].eq;
  assign out_item_o.is_greater     = pipe_q[D-1].gt;
  assign out_item_o.divide_by_zero = pipe_q[D-1].dz;

  // entry stage: simple ops, float-to-fixed, divider setup, product and to_float magnitude
  always_comb begin
    logic [W-1:0]        a, b, amag, bmag;
    logic signed [W-1:0] as, bs;
    logic                sgn;
    logic [7:0]          e;
    logic [22:0]         m;
    logic [63:0]         sig, lim, mag;
    logic signed [11:0]  shf, r;
    stage_t              s;
    a    = in_item_i.a_word[W-1:0];
    b    = in_item_i.b_word[W-1:0];
    as   = $signed(a);
    bs   = $signed(b);
    amag = as < 0 ? W'(-a) : a;
    bmag = bs < 0 ? W'(-b) : b;
    s      = '0;
    s.kind = in_item_i.kind;
    s.num  = QB'(amag) << F;
    s.den  = bmag;
    s.qneg = a[W-1] ^ b[W-1];
    // float decode
    sgn = in_item_i.a_word[31];
    e   = in_item_i.a_word[30:23];
    m   = in_item_i.a_word[22:0];
    sig = (e != 8'd0) ? {40'd0, 1'b1, m} : {40'd0, 1'b0, m};
    lim = sgn ? (64'd1 << (W-1)) : ((64'd1 << (W-1)) - 64'd1);
    shf = ((e == 8'd0) ? 12'sd1 : $signed({4'd0, e})) - 12'sd150 + 12'(F);
    r   = -shf;
    if (e == 8'hFF) begin
      mag = (m != 23'd0) ? 64'd0 : lim;
    end else if (shf >= 0) begin
      if (shf >= 12'sd40) begin
        mag = lim;
      end else begin
        mag = sig << shf[5:0];
        if (mag > lim) mag = lim;
      end
    end else if (r > 12'sd25) begin
      mag = 64'd0;
    end else begin
      mag = (sig + (64'd1 << (r[4:0] - 5'd1))) >> r[4:0];
      if (mag > lim) mag = lim;
    end
    case (in_item_i.kind)
      OP_ADD:      s.res = zx(a + b);
      OP_SUB:      s.res = zx(a - b);
      OP_INC:      s.res = zx(a + W'(1));
      OP_DEC:      s.res = zx(a - W'(1));
      OP_MIN:      s.res = zx(as < bs ? a : b);
      OP_MAX:      s.res = zx(as > bs ? a : b);
      OP_CMP: begin
        s.lt = as < bs;
        s.eq = a == b;
        s.gt = as > bs;
      end
      OP_DIV:      s.dz  = (b == '0);
      OP_FROM_INT: s.res = zx(a << F);
      OP_TO_INT:   s.res = zx(W'(as >>> F));
      OP_FROM_FLT: s.res = zx(sgn ? W'(64'd0 - mag) : W'(mag));
      default:     s.res = '0;
    endcase
    pipe_d[0] = s;
    prod_d    = (2*W)'(as) * (2*W)'(bs);
    tf_neg0_d = as < 0;
    tf_mag0_d = amag;
  end

  // to_float: leading one position
  always_comb begin
    tf_p1_d = '0;
    for (int i = 0; i < W; i++) begin
      if (tf_mag0_q[i]) tf_p1_d = PW'(i);
    end
  end

  for (genvar k = 1; k < D; k++) begin : g_stage
    always_comb begin
      stage_t       s;
      logic signed [2*W-1:0] psh;
      logic [31:0]  mg, rm, hf;
      logic [24:0]  q;
      logic [5:0]   p, rr;
      logic [W-1:0] qw;
      s   = pipe_q[k-1];
      psh = '0;
      mg  = '0;
      rm  = '0;
      hf  = '0;
      q   = '0;
      p   = '0;
      rr  = '0;
      qw  = '0;
      if (k <= QB) s = div_step(s);
      if (k == 1 && s.kind == OP_MUL) begin
        psh   = prod_q >>> F;
        s.res = zx(psh[W-1:0]);
      end
      if (k == 2 && s.kind == OP_TO_FLT) begin
        mg = 32'(tf_mag1_q);
        p  = 6'(tf_p1_q);
        if (mg == 32'd0) begin
          s.res = '0;
        end else begin
          if (p > 6'd23) begin
            rr = p - 6'd23;
            q  = 25'(mg >> rr);
            rm = mg & ((32'd1 << rr) - 32'd1);
            hf = 32'd1 << (rr - 6'd1);
            if (rm > hf || (rm == hf && q[0])) q = q + 25'd1;
            if (q[24]) begin
              q = q >> 1;
              p = p + 6'd1;
            end
          end else begin
            q = 25'(mg << (6'd23 - p));
          end
          s.res = {tf_neg1_q, 8'(p) + EXP_BIAS, q[22:0]};
        end
      end
      if (k == QB + 1 && s.kind == OP_DIV) begin
        qw    = s.qneg ? W'(-s.quo) : W'(s.quo);
        s.res = s.dz ? 32'd0 : zx(qw);
      end
      pipe_d[k] = s;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[D-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < D; k++) pipe_q[k] <= pipe_d[k];
      prod_q    <= prod_d;
      tf_mag0_q <= tf_mag0_d;
      tf_neg0_q <= tf_neg0_d;
      tf_mag1_q <= tf_mag0_q;
      tf_neg1_q <= tf_neg0_q;
      tf_p1_q   <= tf_p1_d;
    end
  end

endmodule
`default_nettype wire

// ----- sv/q24alu_checker.sv -----
// Checker: port-level assertions for the fixed-point ALU, bound to the top level.
`default_nettype none
module q24alu_checker (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  in_stall_o,
  input wire q24alu_pkg::out_item_t out_item_o,
  input wire logic                  out_valid_o,
  input wire logic                  out_stall_i
);
  import q24alu_pkg::*;

  a_stall_follows_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall does not track output backpressure");

  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_item_o))
    else $error("stalled output item changed");

  a_cmp_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0({out_item_o.is_less, out_item_o.is_equal,
                              out_item_o.is_greater}))
    else $error("compare flags not exclusive");

  a_dz_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.divide_by_zero |->
      out_item_o.result_word == 32'd0 && !out_item_o.is_less &&
      !out_item_o.is_equal && !out_item_o.is_greater)
    else $error("divide by zero item carries data");

endmodule

bind q24_8_fixed_point_alu_top q24alu_checker u_q24alu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_item_o  (out_item_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i)
);
`default_nettype wire
